@@ rtl/envelope_follower_gate_top_defines.svh @@
// ----------------------------------------------------------------------------
// Envelope follower gate assertion macros
// Shared property forms for the checker of the envelope follower gate.
// ----------------------------------------------------------------------------
`ifndef ENVELOPE_FOLLOWER_GATE_TOP_DEFINES_SVH
`define ENVELOPE_FOLLOWER_GATE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define EFG_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("envelope follower gate check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define EFG_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("envelope follower gate check failed");

`endif

@@ rtl/efg_pkg.sv @@
// ----------------------------------------------------------------------------
// Envelope follower gate package
// Types, register indices and reset values shared by the block.
// ----------------------------------------------------------------------------
package efg_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int Q15_W           = 15;
	localparam int Q15_MAX         = 32767;
	localparam int CFG_INDEX_W     = 3;
	localparam int CFG_DATA_W      = 15;

	localparam logic [Q15_W-1:0] ATTACK_RST  = 15'd16384;
	localparam logic [Q15_W-1:0] RELEASE_RST = 15'd8192;
	localparam logic [Q15_W-1:0] RISE_RST    = 15'd32767;
	localparam logic [Q15_W-1:0] FALL_RST    = 15'd1024;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ATTACK  = 3'd0,
		REG_RELEASE = 3'd1,
		REG_RISE    = 3'd2,
		REG_FALL    = 3'd3,
		REG_STEREO  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [Q15_W-1:0] attack_level;
		logic [Q15_W-1:0] release_level;
		logic [Q15_W-1:0] rise_coef;
		logic [Q15_W-1:0] fall_coef;
		logic             stereo_mode;
	} cfg_t;

	typedef struct packed {
		logic [Q15_W-1:0] envelope;
		logic             gate_open;
		logic             attack;
		logic             release_hit;
	} upd_t;

endpackage

@@ rtl/efg_cfg.sv @@
// ----------------------------------------------------------------------------
// Envelope follower gate configuration registers
// Holds the thresholds, coefficients and stereo switch.
// ----------------------------------------------------------------------------
module efg_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [efg_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [efg_pkg::CFG_DATA_W-1:0]    cfg_data,
	output efg_pkg::cfg_t                     cfg
);
	import efg_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack_level  <= ATTACK_RST;
			cfg_q.release_level <= RELEASE_RST;
			cfg_q.rise_coef     <= RISE_RST;
			cfg_q.fall_coef     <= FALL_RST;
			cfg_q.stereo_mode   <= 1'b0;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_ATTACK:  cfg_q.attack_level  <= cfg_data[Q15_W-1:0];
				REG_RELEASE: cfg_q.release_level <= cfg_data[Q15_W-1:0];
				REG_RISE:    cfg_q.rise_coef     <= cfg_data[Q15_W-1:0];
				REG_FALL:    cfg_q.fall_coef     <= cfg_data[Q15_W-1:0];
				REG_STEREO:  cfg_q.stereo_mode   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/efg_update.sv @@
// ----------------------------------------------------------------------------
// Envelope follower gate update logic
// One envelope step and the hysteresis gate decision for one frame.
// ----------------------------------------------------------------------------
module efg_update #(
	parameter int SAMPLE_BITS = efg_pkg::SAMPLE_BITS_DEF
) (
	input  logic signed [SAMPLE_BITS-1:0]   left_sample,
	input  logic signed [SAMPLE_BITS-1:0]   right_sample,
	input  logic [efg_pkg::Q15_W-1:0]       envelope,
	input  logic                            gate_open,
	input  efg_pkg::cfg_t                   cfg,
	output efg_pkg::upd_t                   upd
);
	import efg_pkg::*;

	localparam int SUM_W = (SAMPLE_BITS + 1 > Q15_W + 2) ? SAMPLE_BITS + 1 : Q15_W + 2;
	localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(Q15_MAX);
	localparam logic signed [Q15_W+2:0] NEXT_MAX = (Q15_W + 3)'(Q15_MAX);

	logic signed [SUM_W-1:0]   left_ext;
	logic signed [SUM_W-1:0]   right_ext;
	logic signed [SUM_W-1:0]   sum;
	logic signed [SUM_W-1:0]   env_ext;
	logic [Q15_W-1:0]          target;
	logic [Q15_W-1:0]          coef;
	logic signed [Q15_W:0]     diff;
	logic signed [2*Q15_W+1:0] prod;
	logic signed [Q15_W+1:0]   step;
	logic signed [Q15_W+2:0]   next;
	logic [Q15_W-1:0]          env_new;

	assign left_ext  = SUM_W'(left_sample);
	assign right_ext = SUM_W'(right_sample);
	assign sum       = left_ext + (cfg.stereo_mode ? right_ext : '0);
	assign env_ext   = $signed(SUM_W'({1'b0, envelope}));

	always_comb begin
		if (sum[SUM_W-1]) begin
			target = '0;
		end else if (sum > SUM_MAX) begin
			target = Q15_W'(Q15_MAX);
		end else begin
			target = sum[Q15_W-1:0];
		end
	end

	// The rise coefficient applies against the unclamped sum.
	assign coef = (env_ext < sum) ? cfg.rise_coef : cfg.fall_coef;
	assign diff = $signed({1'b0, target}) - $signed({1'b0, envelope});
	assign prod = diff * $signed({1'b0, coef});
	// Taking the upper bits is an arithmetic shift, so the step rounds to floor.
	assign step = prod[2*Q15_W+1:Q15_W];
	assign next = (Q15_W + 3)'(step) + $signed((Q15_W + 3)'({1'b0, envelope}));

	always_comb begin
		if (next[Q15_W+2]) begin
			env_new = '0;
		end else if (next > NEXT_MAX) begin
			env_new = Q15_W'(Q15_MAX);
		end else begin
			env_new = next[Q15_W-1:0];
		end
	end

	// Only opening is tested while closed, only closing while open.
	always_comb begin
		upd.envelope    = env_new;
		upd.gate_open   = gate_open;
		upd.attack      = 1'b0;
		upd.release_hit = 1'b0;
		if (!gate_open && (env_new > cfg.attack_level)) begin
			upd.gate_open = 1'b1;
			upd.attack    = 1'b1;
		end else if (gate_open && (env_new < cfg.release_level)) begin
			upd.gate_open   = 1'b0;
			upd.release_hit = 1'b1;
		end
	end

endmodule

@@ rtl/envelope_follower_gate_top.sv @@
// A word accepted into the input stage goes through the update into the result register.
// Throughput: one frame per cycle unless the result side stalls; the envelope and
// gate update is a single multiply in the stage between input and result registers.
// Reset (arst_n low, asynchronous) clears the envelope and closes the gate, empties
// both stages and loads the registers with their default values.
// ----------------------------------------------------------------------------
// Envelope follower gate top level
// Q15 envelope follower with a hysteresis gate, one frame in per cycle unless stalled.
// ----------------------------------------------------------------------------
module envelope_follower_gate_top #(
	parameter int SAMPLE_BITS = efg_pkg::SAMPLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Configuration write port.
	input  logic                             cfg_wen,
	input  logic [efg_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [efg_pkg::CFG_DATA_W-1:0]   cfg_data,
	// Sample channel.
	input  logic                             sample_valid,
	output logic                             sample_stall,
	input  logic signed [SAMPLE_BITS-1:0]    left_sample,
	input  logic signed [SAMPLE_BITS-1:0]    right_sample,
	// Result channel.
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic [efg_pkg::Q15_W-1:0]        envelope_level,
	output logic                             gate_active,
	output logic                             attack_pulse,
	output logic                             release_pulse
);
	import efg_pkg::*;

	cfg_t                    cfg;
	upd_t                    upd;

	// Input stage: the accepted word waits here for the update.
	logic                    valid_s1;
	logic signed [SAMPLE_BITS-1:0] left_s1;
	logic signed [SAMPLE_BITS-1:0] right_s1;

	// Follower state, committed as each word passes into the result register.
	logic [Q15_W-1:0]        envelope_q;
	logic                    open_q;

	// Result register.
	logic                    res_valid_q;
	upd_t                    res_q;

	logic                    res_free;
	logic                    advance;
	logic                    load_s1;

	efg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	efg_update #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_update (
		.left_sample  (left_s1),
		.right_sample (right_s1),
		.envelope     (envelope_q),
		.gate_open    (open_q),
		.cfg          (cfg),
		.upd          (upd)
	);

	// The result register can take a word when it is empty or being emptied.
	// The input stage moves on whenever the result register can take it, so a
	// new word is accepted every cycle unless the result side holds back.
	assign res_free     = !res_valid_q || !result_stall;
	assign advance      = valid_s1 && res_free;
	assign load_s1      = !valid_s1 || res_free;
	assign sample_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && sample_valid) begin
			left_s1  <= left_sample;
			right_s1 <= right_sample;
		end
	end

	// The state is only updated together with the result register, so each word
	// sees exactly the envelope left by the word before it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			envelope_q <= '0;
			open_q     <= 1'b0;
		end else if (advance) begin
			envelope_q <= upd.envelope;
			open_q     <= upd.gate_open;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= upd;
		end
	end

	assign result_valid   = res_valid_q;
	assign envelope_level = res_q.envelope;
	assign gate_active    = res_q.gate_open;
	assign attack_pulse   = res_q.attack;
	assign release_pulse  = res_q.release_hit;

endmodule

@@ rtl/efg_checker.sv @@
// ----------------------------------------------------------------------------
// Envelope follower gate checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "envelope_follower_gate_top_defines.svh"

module efg_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        result_valid,
	input logic                        result_stall,
	input logic [efg_pkg::Q15_W-1:0]   envelope_level,
	input logic                        gate_active,
	input logic                        attack_pulse,
	input logic                        release_pulse
);
	import efg_pkg::*;

	// A held result keeps its envelope level and gate state.
	`EFG_ASSERT_NXT(a_hold, result_valid && result_stall, result_valid && $stable(envelope_level) && $stable(gate_active))

	// Opening and closing cannot happen on the same frame.
	`EFG_ASSERT_IMP(a_one_pulse, result_valid, !(attack_pulse && release_pulse))

	// An opening leaves the gate open.
	`EFG_ASSERT_IMP(a_attack_open, result_valid && attack_pulse, gate_active)

	// A closing leaves the gate closed.
	`EFG_ASSERT_IMP(a_release_closed, result_valid && release_pulse, !gate_active)

endmodule

bind envelope_follower_gate_top efg_checker u_efg_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.result_valid   (result_valid),
	.result_stall   (result_stall),
	.envelope_level (envelope_level),
	.gate_active    (gate_active),
	.attack_pulse   (attack_pulse),
	.release_pulse  (release_pulse)
);
